// ===== hdl/mlrq_pkg.sv =====
// Package for the multilevel ready queue: sizes, transaction kind codes and result status codes.
// It depends on nothing. The RAM and the top level both use it.
`default_nettype none

package mlrq_pkg;

    localparam int LEVELS     = 3;
    localparam int POOL_DEPTH = 64;

    localparam int KIND_W   = 2;
    localparam int LEVEL_W  = 2;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 2;

    // Transaction kinds
    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/multilevel_ready_queue_top.sv =====
// Multilevel ready queue: LEVELS first-in first-out queues of process ids kept as linked lists in
// one shared pool of POOL_DEPTH entries. Depends on mlrq_pkg and mlrq_ram.
//
// Each input transaction is an enqueue, a dequeue or a remove on one priority level, and each
// gives exactly one result transaction carrying the dequeued pid (else zero), a status code and
// an all-levels-empty flag. The block works on one transaction at a time and drops s_axis_tready
// until it is done. After acceptance an enqueue or a dequeue has one state of its own, and a
// rejected or unused-kind transaction goes straight to the result state. A remove walks the
// list of its level in S_WALK and frees a matching entry in S_REM_FREE; the walk is paced by
// the single read port of the link memory, as each step of it needs one registered read.
// A finished result sits in the output register, so the next transaction is accepted while
// that result still waits for m_axis_tready; a result only holds the sequencer when the
// previous one has not been taken yet.
// Returned pool entries are handed out first, from the chain of returned entries; never-used
// entries come from a fill count, so the pool needs no clearing pass after reset.
`default_nettype none

module multilevel_ready_queue_top #(
    parameter int LEVELS     = mlrq_pkg::LEVELS,
    parameter int POOL_DEPTH = mlrq_pkg::POOL_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input transactions
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [1:0] level, [17:2] pid, [23:18] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    // Result transactions
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [15:0] out_pid
    output logic      [2:0]  m_axis_tuser    // [1:0] status, [2] all_empty
);

    localparam int PW  = $clog2(POOL_DEPTH);
    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PDW = mlrq_pkg::PID_W;
    localparam int SW  = mlrq_pkg::STATUS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_WALK,
        S_REM_FREE,
        S_RESP
    } t_state;

    // Sequencer and list state
    t_state            r_state, n_state;
    logic [PW-1:0]     r_head [LEVELS];
    logic [PW-1:0]     n_head [LEVELS];
    logic [PW-1:0]     r_tail [LEVELS];
    logic [PW-1:0]     n_tail [LEVELS];
    logic [CW-1:0]     r_cnt  [LEVELS];
    logic [CW-1:0]     n_cnt  [LEVELS];
    logic [PW-1:0]     r_free_head, n_free_head;
    logic [CW-1:0]     r_free_count, n_free_count;
    logic [CW-1:0]     r_fill, n_fill;

    // Working registers of the transaction in flight
    logic [LW-1:0]     r_lv, n_lv;
    logic [PDW-1:0]    r_pid, n_pid;
    logic [PW-1:0]     r_cur, n_cur;
    logic [PW-1:0]     r_prev, n_prev;
    logic [CW-1:0]     r_k, n_k;
    logic [SW-1:0]     r_res_status, n_res_status;

    // Output register
    logic              r_m_valid, n_m_valid;
    logic [PDW-1:0]    r_m_pid, n_m_pid;
    logic [SW-1:0]     r_m_status, n_m_status;
    logic              r_m_all_empty, n_m_all_empty;

    // Memory ports
    logic [PW-1:0]     w_raddr;
    logic [PDW-1:0]    w_pid_rdata;
    logic [PW-1:0]     w_link_rdata;
    logic              w_pid_we;
    logic              w_link_we;
    logic [PW-1:0]     w_link_waddr;
    logic [PW-1:0]     w_link_wdata;

    // Incoming fields
    logic [1:0]        w_in_kind;
    logic [1:0]        w_in_level;
    logic [PDW-1:0]    w_in_pid;
    logic              w_in_lv_ok;
    logic [LW-1:0]     w_in_lv;
    logic              w_out_free;

    assign w_in_kind  = s_axis_tuser;
    assign w_in_level = s_axis_tdata[1:0];
    assign w_in_pid   = s_axis_tdata[17:2];
    assign w_in_lv_ok = (32'(w_in_level) < 32'(LEVELS));
    assign w_in_lv    = w_in_lv_ok ? LW'(w_in_level) : '0;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Entry pids; written only at enqueue
    mlrq_ram #(
        .WIDTH (PDW),
        .DEPTH (POOL_DEPTH)
    ) u_pid_ram (
        .i_clk   (i_clk),
        .i_we    (w_pid_we),
        .i_waddr (r_cur),
        .i_wdata (r_pid),
        .i_raddr (w_raddr),
        .o_rdata (w_pid_rdata)
    );

    // Links: an entry in a level links to its successor, a free entry to the next free one
    mlrq_ram #(
        .WIDTH (PW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_link_rdata)
    );

    always_comb begin
        logic          v_match;
        logic          v_last;
        logic          v_fresh;
        logic          v_load;
        logic [CW-1:0] v_cnt;

        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_cnt         = r_cnt;
        n_free_head   = r_free_head;
        n_free_count  = r_free_count;
        n_fill        = r_fill;
        n_lv          = r_lv;
        n_pid         = r_pid;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_k           = r_k;
        n_res_status  = r_res_status;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_pid       = r_m_pid;
        n_m_status    = r_m_status;
        n_m_all_empty = r_m_all_empty;

        w_raddr      = r_cur;
        w_pid_we     = 1'b0;
        w_link_we    = 1'b0;
        w_link_waddr = r_cur;
        w_link_wdata = r_free_head;

        v_cnt   = r_cnt[r_lv];
        v_match = (w_pid_rdata == r_pid);
        v_last  = (CW'(r_k + 1'b1) == v_cnt);
        v_fresh = (CW'(r_cur) >= r_fill);
        v_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Issue the first read in the accept cycle
                w_raddr = (w_in_kind == mlrq_pkg::KIND_ENQUEUE) ? r_free_head
                                                                : r_head[w_in_lv];
                if (s_axis_tvalid) begin
                    n_lv  = w_in_lv;
                    n_pid = w_in_pid;
                    n_k   = '0;
                    n_cur = w_raddr;
                    case (w_in_kind)
                        mlrq_pkg::KIND_ENQUEUE: begin
                            if (!w_in_lv_ok || r_free_count == '0) begin
                                n_res_status = mlrq_pkg::ST_FULL;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_ENQ;
                            end
                        end
                        mlrq_pkg::KIND_DEQUEUE: begin
                            if (!w_in_lv_ok || r_cnt[w_in_lv] == '0) begin
                                n_res_status = mlrq_pkg::ST_EMPTY;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_DEQ;
                            end
                        end
                        mlrq_pkg::KIND_REMOVE: begin
                            if (!w_in_lv_ok || r_cnt[w_in_lv] == '0) begin
                                n_res_status = mlrq_pkg::ST_NOTFOUND;
                                n_state      = S_RESP;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_res_status = mlrq_pkg::ST_OK;
                            n_state      = S_RESP;
                        end
                    endcase
                end
            end

            S_ENQ: begin
                if (w_out_free) begin
                    w_pid_we = 1'b1;
                    // A never-used entry chains to its neighbour; a returned one through the RAM
                    if (v_fresh) begin
                        n_free_head = (r_cur == PW'(POOL_DEPTH - 1)) ? '0 : r_cur + 1'b1;
                        n_fill      = r_fill + 1'b1;
                    end else begin
                        n_free_head = w_link_rdata;
                    end
                    n_free_count = r_free_count - 1'b1;
                    if (v_cnt == '0) begin
                        n_head[r_lv] = r_cur;
                    end else begin
                        w_link_we    = 1'b1;
                        w_link_waddr = r_tail[r_lv];
                        w_link_wdata = r_cur;
                    end
                    n_tail[r_lv]  = r_cur;
                    n_cnt[r_lv]   = v_cnt + 1'b1;
                    n_res_status  = mlrq_pkg::ST_OK;
                    n_m_pid       = '0;
                    v_load        = 1'b1;
                end
            end

            S_DEQ: begin
                if (w_out_free) begin
                    n_head[r_lv] = w_link_rdata;
                    n_cnt[r_lv]  = v_cnt - 1'b1;
                    // Push the entry back on the free chain
                    w_link_we    = 1'b1;
                    n_free_head  = r_cur;
                    n_free_count = r_free_count + 1'b1;
                    n_res_status = mlrq_pkg::ST_OK;
                    n_m_pid      = w_pid_rdata;
                    v_load       = 1'b1;
                end
            end

            S_WALK: begin
                w_raddr = w_link_rdata;
                if (v_match) begin
                    // Unlink the matching entry; it goes back to the free chain in S_REM_FREE once the output is free
                    if (r_k == '0) begin
                        n_head[r_lv] = w_link_rdata;
                    end else begin
                        w_link_we    = 1'b1;
                        w_link_waddr = r_prev;
                        w_link_wdata = w_link_rdata;
                    end
                    if (v_last) begin
                        n_tail[r_lv] = r_prev;
                    end
                    n_cnt[r_lv] = v_cnt - 1'b1;
                    n_state     = S_REM_FREE;
                end else if (v_last) begin
                    n_res_status = mlrq_pkg::ST_NOTFOUND;
                    n_state      = S_RESP;
                end else begin
                    n_prev = r_cur;
                    n_cur  = w_link_rdata;
                    n_k    = r_k + 1'b1;
                end
            end

            S_REM_FREE: begin
                if (w_out_free) begin
                    w_link_we    = 1'b1;
                    n_free_head  = r_cur;
                    n_free_count = r_free_count + 1'b1;
                    n_res_status = mlrq_pkg::ST_OK;
                    n_m_pid      = '0;
                    v_load       = 1'b1;
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_m_pid = '0;
                    v_load  = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result and return to idle
        if (v_load) begin
            n_m_valid     = 1'b1;
            n_m_status    = n_res_status;
            n_m_all_empty = (n_free_count == CW'(POOL_DEPTH));
            n_state       = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_free_count <= CW'(POOL_DEPTH);
            r_fill       <= '0;
            r_m_valid    <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_cnt        <= n_cnt;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_fill       <= n_fill;
            r_m_valid    <= n_m_valid;
        end
        r_lv          <= n_lv;
        r_pid         <= n_pid;
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_k           <= n_k;
        r_res_status  <= n_res_status;
        r_m_pid       <= n_m_pid;
        r_m_status    <= n_m_status;
        r_m_all_empty <= n_m_all_empty;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_pid;
    assign m_axis_tuser  = {r_m_all_empty, r_m_status};

endmodule

`default_nettype wire

// ===== hdl/mlrq_ram.sv =====
// Generic single write port RAM with one registered read port.
// Depends on mlrq_pkg for its default sizes.
`default_nettype none

module mlrq_ram #(
    parameter int WIDTH = mlrq_pkg::PID_W,
    parameter int DEPTH = mlrq_pkg::POOL_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for multilevel_ready_queue_top: directed and random enqueue, dequeue and remove
// traffic with random stalls on both streams, checked against a behavioural scoreboard.
// Depends on mlrq_pkg and the block under test.
`default_nettype none

module tb_top;

    localparam int KIND_W   = mlrq_pkg::KIND_W;
    localparam int LEVEL_W  = mlrq_pkg::LEVEL_W;
    localparam int PID_W    = mlrq_pkg::PID_W;
    localparam int STATUS_W = mlrq_pkg::STATUS_W;

    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_OUT   = LEVEL_W'(mlrq_pkg::LEVELS);

    // Behavioural view of the ready queues: every live entry in arrival order together with its
    // level, which keeps per-level FIFO order without modelling the link memory.
    class rq_scoreboard;
        typedef struct packed {
            logic [PID_W-1:0]    pid;
            logic [STATUS_W-1:0] status;
            logic                all_empty;
        } t_outcome;

        typedef struct packed {
            logic [LEVEL_W-1:0] level;
            logic [PID_W-1:0]   pid;
        } t_entry;

        t_entry   live_entries[$];
        t_outcome awaited[$];
        int       fails;

        function new();
            fails = 0;
        endfunction

        task report(input string what);
            fails++;
            if (fails <= 40)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        // Position of the first entry of a level, optionally with a matching pid; -1 if none.
        function int locate(input logic [LEVEL_W-1:0] level, input logic [PID_W-1:0] pid,
                            input bit by_pid);
            for (int i = 0; i < live_entries.size(); i++)
                if (live_entries[i].level == level && (!by_pid || live_entries[i].pid == pid))
                    return i;
            return -1;
        endfunction

        // Pick the pid of a random entry held in a level, for removes that should hit.
        function bit sample_pid(input logic [LEVEL_W-1:0] level, output logic [PID_W-1:0] pid);
            int hits[$];
            pid = '0;
            foreach (live_entries[i])
                if (live_entries[i].level == level)
                    hits.push_back(i);
            if (hits.size() == 0)
                return 1'b0;
            pid = live_entries[hits[$urandom_range(0, hits.size() - 1)]].pid;
            return 1'b1;
        endfunction

        function void note_request(input logic [KIND_W-1:0] kind,
                                   input logic [LEVEL_W-1:0] level,
                                   input logic [PID_W-1:0] pid);
            t_outcome res;
            int       pos;
            res.pid    = '0;
            res.status = mlrq_pkg::ST_OK;
            case (kind)
                mlrq_pkg::KIND_ENQUEUE: begin
                    if (level >= LEVEL_OUT || live_entries.size() >= mlrq_pkg::POOL_DEPTH)
                        res.status = mlrq_pkg::ST_FULL;
                    else
                        live_entries.push_back('{level: level, pid: pid});
                end
                mlrq_pkg::KIND_DEQUEUE: begin
                    pos = locate(level, pid, 1'b0);
                    if (pos < 0) begin
                        res.status = mlrq_pkg::ST_EMPTY;
                    end else begin
                        res.pid = live_entries[pos].pid;
                        live_entries.delete(pos);
                    end
                end
                mlrq_pkg::KIND_REMOVE: begin
                    pos = locate(level, pid, 1'b1);
                    if (pos < 0)
                        res.status = mlrq_pkg::ST_NOTFOUND;
                    else
                        live_entries.delete(pos);
                end
                default: ;
            endcase
            res.all_empty = (live_entries.size() == 0);
            awaited.push_back(res);
        endfunction

        task check_result(input logic [PID_W-1:0] pid, input logic [STATUS_W-1:0] status,
                          input logic all_empty);
            t_outcome want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result pid %h status %0d", pid, status));
                return;
            end
            want = awaited.pop_front();
            if (pid !== want.pid)
                report($sformatf("out_pid %h, want %h", pid, want.pid));
            if (status !== want.status)
                report($sformatf("status %0d, want %0d", status, want.status));
            if (all_empty !== want.all_empty)
                report($sformatf("all_empty %b, want %b", all_empty, want.all_empty));
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata   = '0;   // [1:0] level, [17:2] pid, [23:18] zero
    logic [1:0]  s_axis_tuser   = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] out_pid
    logic [2:0]  m_axis_tuser;          // [1:0] status, [2] all_empty

    bit           idle_enabled = 1'b1;
    rq_scoreboard sb = new();

    multilevel_ready_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Offer one transaction, optionally after an idle burst, and hold it until accepted.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [LEVEL_W-1:0] level,
                                input logic [PID_W-1:0] pid);
        if (idle_enabled && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, pid, level};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(kind, level, pid);
        @(negedge i_clk);
    endtask

    function automatic logic [PID_W-1:0] random_pid();
        case ($urandom_range(0, 3))
            0:       return PID_W'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return PID_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result side: stall in random bursts while idling is enabled, otherwise always take.
    initial begin : result_sink
        int stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && idle_enabled && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2]);
    end

    initial begin : stimulus
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] level;
        logic [PID_W-1:0]   pid;
        int                 enq_pct;
        int                 roll;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty levels, out-of-range level, unused kind, field extremes,
        // removes at head, middle and tail, duplicates and a miss in a non-empty level.
        send_request(mlrq_pkg::KIND_DEQUEUE, 2'd0, 16'h0000);
        send_request(mlrq_pkg::KIND_REMOVE,  2'd1, 16'h0005);
        send_request(mlrq_pkg::KIND_ENQUEUE, LEVEL_OUT, 16'hFFFF);
        send_request(mlrq_pkg::KIND_DEQUEUE, LEVEL_OUT, 16'h0000);
        send_request(mlrq_pkg::KIND_REMOVE,  LEVEL_OUT, 16'hFFFF);
        send_request(KIND_UNUSED,            2'd0, 16'hFFFF);
        send_request(mlrq_pkg::KIND_ENQUEUE, 2'd0, 16'h0000);
        send_request(mlrq_pkg::KIND_ENQUEUE, 2'd0, 16'hFFFF);
        send_request(mlrq_pkg::KIND_ENQUEUE, 2'd1, 16'hFFFF);
        send_request(mlrq_pkg::KIND_ENQUEUE, 2'd2, 16'h1234);
        send_request(mlrq_pkg::KIND_ENQUEUE, 2'd2, 16'hFFFF);
        send_request(mlrq_pkg::KIND_ENQUEUE, 2'd2, 16'h1234);
        send_request(KIND_UNUSED,            2'd2, 16'h0000);
        send_request(mlrq_pkg::KIND_REMOVE,  2'd2, 16'hFFFF);
        send_request(mlrq_pkg::KIND_REMOVE,  2'd2, 16'h1234);
        send_request(mlrq_pkg::KIND_REMOVE,  2'd2, 16'h1234);
        send_request(mlrq_pkg::KIND_REMOVE,  2'd0, 16'hAAAA);
        send_request(mlrq_pkg::KIND_REMOVE,  2'd0, 16'hFFFF);
        send_request(mlrq_pkg::KIND_DEQUEUE, 2'd1, 16'h5555);
        send_request(mlrq_pkg::KIND_DEQUEUE, 2'd0, 16'h0000);
        send_request(mlrq_pkg::KIND_DEQUEUE, 2'd2, 16'h0000);
        send_request(KIND_UNUSED,            LEVEL_OUT, 16'h0000);

        // Random: phases alternate between filling, churning and draining, so the pool runs
        // full and empty repeatedly; the last phases run without any idling.
        for (int phase = 0; phase < 13; phase++) begin
            idle_enabled = (phase < 11) && (phase % 4 != 2);
            case (phase % 3)
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 20;
            endcase
            for (int n = 0; n < 100; n++) begin
                roll  = $urandom_range(0, 99);
                level = ($urandom_range(0, 19) == 0) ? LEVEL_OUT : LEVEL_W'($urandom_range(0, 2));
                pid   = random_pid();
                if (roll < enq_pct)
                    kind = mlrq_pkg::KIND_ENQUEUE;
                else if (roll >= 97)
                    kind = KIND_UNUSED;
                else if (roll % 2 == 0)
                    kind = mlrq_pkg::KIND_DEQUEUE;
                else
                    kind = mlrq_pkg::KIND_REMOVE;
                // Aim most removes at a pid that the level really holds.
                if (kind == mlrq_pkg::KIND_REMOVE && $urandom_range(0, 3) != 0)
                    void'(sb.sample_pid(level, pid));
                send_request(kind, level, pid);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give a stray result time to show up.
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (sb.awaited.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
        if (sb.fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/mlrq_pkg.sv
hdl/mlrq_ram.sv
hdl/multilevel_ready_queue_top.sv
sim/tb_top.sv
